// File: rtl/core/rau_pkg.sv
package rau_pkg;

   localparam int unsigned OPERAND_WIDTH_DEF = 16;
   localparam int unsigned NUM_W = 32;
   localparam int unsigned DEN_W = 30;
   localparam int unsigned ACC_W = 66;

   typedef enum logic [2:0] {
      MODE_ADD = 3'd0,
      MODE_SUB = 3'd1,
      MODE_MUL = 3'd2,
      MODE_DIV = 3'd3,
      MODE_EQ  = 3'd4,
      MODE_NE  = 3'd5
   } mode_type;

   typedef struct packed {
      logic [2:0]         mode;
      logic signed [15:0] a_num;
      logic [14:0]        a_den;
      logic signed [15:0] b_num;
      logic [14:0]        b_den;
   } req_type;

   typedef struct packed {
      logic signed [31:0] result_num;
      logic [29:0]        result_den;
      logic               compare_true;
      logic               div_zero;
   } rsp_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_MUL1,
      ST_MUL2,
      ST_FORM,
      ST_GCD_INIT,
      ST_GCD_DIV,
      ST_GCD_STEP,
      ST_RED_NUM,
      ST_RED_DEN,
      ST_DONE
   } state_type;

   // controller -> datapath
   typedef struct packed {
      logic load;
      logic mul1;
      logic mul2;
      logic form;
      logic gcd_init;
      logic div_start;
      logic gcd_step;
      logic red_num;
      logic red_den;
      logic finish;
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic arith;
      logic den_zero;
      logic y_zero;
      logic div_done;
   } sts_type;

endpackage

// File: rtl/core/rational_arithmetic_unit.sv
// Rational arithmetic unit: add, subtract, multiply, divide, equal and
// not equal on two fractions, results reduced by Euclid's gcd.
// Request channel: drive req_data and raise start; the beat is taken at
// the rising edge where start is high and busy is low. busy falls at the
// edge that raises rsp_valid, so the next beat may be taken at the end
// of the cycle in which the result is shown.
// Response channel: rsp_valid is high for exactly one cycle with the beat
// on rsp_data; the receiver cannot stall it, so capture it then.
// Compare modes, spare codes and zero-denominator cases go straight to
// the result. Arithmetic runs Euclid remainder steps: every step, and the
// two final reductions of numerator and denominator, go through one
// shared 66-bit restoring divider at one quotient bit per cycle.
// One item is in flight at a time.
// Reset (synchronous, active high) returns the controller to idle and
// drops any item in progress; no result appears for it.
module rational_arithmetic_unit #(
   parameter int unsigned OPERAND_WIDTH = rau_pkg::OPERAND_WIDTH_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  rau_pkg::req_type req_data,
   output logic             rsp_valid,
   output rau_pkg::rsp_type rsp_data
);
   rau_pkg::cmd_type cmd;
   rau_pkg::sts_type sts;

   // sequence the load, products, gcd loop and reduction
   rau_control u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .sts    (sts),
      .cmd    (cmd),
      .busy   (busy),
      .strobe (rsp_valid)
   );

   // hold operands, products, gcd state and the result register
   rau_datapath #(.OPERAND_WIDTH(OPERAND_WIDTH)) u_dp (
      .clock    (clock),
      .req      (req_data),
      .cmd      (cmd),
      .sts      (sts),
      .rsp_data (rsp_data)
   );
endmodule

// File: rtl/core/rau_divider.sv
module rau_divider #(
   parameter int unsigned WIDTH = rau_pkg::ACC_W
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [WIDTH-1:0] dividend,
   input  logic [WIDTH-1:0] divisor,
   output logic             done,
   output logic [WIDTH-1:0] quotient,
   output logic [WIDTH-1:0] remainder
);
   localparam int unsigned CW = $clog2(WIDTH + 1);

   logic [WIDTH-1:0] quo_ff, quo_in, rem_ff, rem_in, dsr_ff, dsr_in;
   logic [CW-1:0]    cnt_ff, cnt_in;
   logic             run_ff, run_in, done_ff, done_in;
   logic [WIDTH:0]   trial;

   // restoring division, one quotient bit a cycle
   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      cnt_in  = cnt_ff;
      run_in  = run_ff;
      done_in = 1'b0;
      trial   = '0;
      if (start) begin
         quo_in = dividend;
         rem_in = '0;
         dsr_in = divisor;
         cnt_in = CW'(WIDTH);
         run_in = 1'b1;
      end else if (run_ff) begin
         trial = {rem_ff, quo_ff[WIDTH-1]} - {1'b0, dsr_ff};
         if (!trial[WIDTH]) begin
            rem_in = trial[WIDTH-1:0];
            quo_in = {quo_ff[WIDTH-2:0], 1'b1};
         end else begin
            rem_in = {rem_ff[WIDTH-2:0], quo_ff[WIDTH-1]};
            quo_in = {quo_ff[WIDTH-2:0], 1'b0};
         end
         cnt_in = cnt_ff - CW'(1);
         if (cnt_ff == CW'(1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
      end
   end

   assign done      = done_ff;
   assign quotient  = quo_ff;
   assign remainder = rem_ff;
endmodule

// File: rtl/core/rau_datapath.sv
module rau_datapath #(
   parameter int unsigned OPERAND_WIDTH = rau_pkg::OPERAND_WIDTH_DEF
) (
   input  logic             clock,
   input  rau_pkg::req_type req,
   input  rau_pkg::cmd_type cmd,
   output rau_pkg::sts_type sts,
   output rau_pkg::rsp_type rsp_data
);
   localparam int unsigned W  = OPERAND_WIDTH;
   localparam int unsigned AW = rau_pkg::ACC_W;

   logic [2:0]             mode_ff;
   logic signed [W-1:0]    an_ff, bn_ff;
   logic signed [W:0]      ad_ff, bd_ff;
   logic signed [2*W+1:0]  p1_ff, p2_ff, p3_ff;
   logic signed [AW-1:0]   n_ff, d_ff;
   logic [AW-1:0]          x_ff, y_ff;
   logic                   cmp_ff;
   rau_pkg::rsp_type       out_ff;

   logic [W-1:0]           an_raw, bn_raw;
   logic [W-2:0]           ad_raw, bd_raw;
   logic signed [2*W+1:0]  m1, m2;
   logic                   div_start;
   logic [AW-1:0]          dvd, dsr, quo, rem, nmag, dmag;
   logic                   div_done;
   logic                   n_neg, d_neg;
   logic signed [AW-1:0]   q_s;

   assign an_raw = W'($unsigned(req.a_num));
   assign bn_raw = W'($unsigned(req.b_num));
   assign ad_raw = (W-1)'(req.a_den);
   assign bd_raw = (W-1)'(req.b_den);

   // first stage: cross products (straight products for multiply), one multiplier per product
   always_comb begin
      unique case (rau_pkg::mode_type'(mode_ff))
         rau_pkg::MODE_MUL: begin
            m1 = (2*W+2)'(an_ff) * (2*W+2)'(bn_ff);
            m2 = (2*W+2)'(ad_ff) * (2*W+2)'(bd_ff);
         end
         rau_pkg::MODE_DIV: begin
            m1 = (2*W+2)'(an_ff) * (2*W+2)'(bd_ff);
            m2 = (2*W+2)'(ad_ff) * (2*W+2)'(bn_ff);
         end
         default: begin
            m1 = (2*W+2)'(an_ff) * (2*W+2)'(bd_ff);
            m2 = (2*W+2)'(bn_ff) * (2*W+2)'(ad_ff);
         end
      endcase
   end

   assign nmag  = n_ff[AW-1] ? AW'(-n_ff) : AW'(n_ff);
   assign dmag  = d_ff[AW-1] ? AW'(-d_ff) : AW'(d_ff);
   assign n_neg = n_ff[AW-1];
   assign d_neg = d_ff[AW-1];

   always_comb begin
      div_start = cmd.div_start | cmd.red_num | cmd.red_den;
      dvd = x_ff;
      dsr = y_ff;
      if (cmd.red_num) begin
         dvd = nmag;
         dsr = x_ff;
      end else if (cmd.red_den) begin
         dvd = dmag;
         dsr = x_ff;
      end
   end

   rau_divider #(.WIDTH(AW)) u_div (
      .clock     (clock),
      .reset     (1'b0),
      .start     (div_start),
      .dividend  (dvd),
      .divisor   (dsr),
      .done      (div_done),
      .quotient  (quo),
      .remainder (rem)
   );

   assign q_s = $signed(quo);

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         mode_ff <= req.mode;
         an_ff   <= $signed(an_raw);
         bn_ff   <= $signed(bn_raw);
         ad_ff   <= $signed({1'b0, ad_raw, 1'b0}) >>> 1;
         bd_ff   <= $signed({1'b0, bd_raw, 1'b0}) >>> 1;
      end
      if (cmd.mul1) begin
         p1_ff <= m1;
         p2_ff <= m2;
      end
      if (cmd.mul2) begin
         p3_ff <= (2*W+2)'(ad_ff) * (2*W+2)'(bd_ff);
      end
      if (cmd.form) begin
         unique case (rau_pkg::mode_type'(mode_ff))
            rau_pkg::MODE_ADD: begin
               n_ff <= AW'(p1_ff) + AW'(p2_ff);
               d_ff <= AW'(p3_ff);
            end
            rau_pkg::MODE_MUL, rau_pkg::MODE_DIV: begin
               n_ff <= AW'(p1_ff);
               d_ff <= AW'(p2_ff);
            end
            default: begin
               n_ff <= AW'(p1_ff) - AW'(p2_ff);
               d_ff <= AW'(p3_ff);
            end
         endcase
         cmp_ff <= (p1_ff == p2_ff);
      end
      if (cmd.gcd_init) begin
         x_ff <= nmag;
         y_ff <= dmag;
      end
      if (cmd.gcd_step) begin
         x_ff <= y_ff;
         y_ff <= rem;
      end
      if (cmd.red_den) begin
         n_ff <= d_neg ? -(n_neg ? -q_s : q_s) : (n_neg ? -q_s : q_s);
      end
      if (cmd.finish) begin
         out_ff.compare_true <= 1'b0;
         out_ff.div_zero     <= 1'b0;
         out_ff.result_num   <= '0;
         out_ff.result_den   <= 30'd1;
         if (mode_ff == rau_pkg::MODE_EQ) begin
            out_ff.compare_true <= cmp_ff;
         end else if (mode_ff == rau_pkg::MODE_NE) begin
            out_ff.compare_true <= !cmp_ff;
         end else if (mode_ff <= rau_pkg::MODE_DIV) begin
            if (d_ff == '0) begin
               out_ff.div_zero   <= 1'b1;
               out_ff.result_num <= n_ff[31:0];
               out_ff.result_den <= '0;
            end else begin
               out_ff.result_num <= n_ff[31:0];
               out_ff.result_den <= quo[29:0];
            end
         end
      end
   end

   assign sts.arith    = (mode_ff <= rau_pkg::MODE_DIV);
   assign sts.den_zero = (d_ff == '0);
   assign sts.y_zero   = (y_ff == '0);
   assign sts.div_done = div_done;
   assign rsp_data     = out_ff;
endmodule

// File: rtl/core/rau_control.sv
module rau_control (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  rau_pkg::sts_type sts,
   output rau_pkg::cmd_type cmd,
   output logic             busy,
   output logic             strobe
);
   rau_pkg::state_type state_ff, state_in;
   logic               strobe_ff;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         rau_pkg::ST_IDLE:     if (start) state_in = rau_pkg::ST_MUL1;
         rau_pkg::ST_MUL1:     state_in = rau_pkg::ST_MUL2;
         rau_pkg::ST_MUL2:     state_in = rau_pkg::ST_FORM;
         rau_pkg::ST_FORM:     state_in = rau_pkg::ST_GCD_INIT;
         rau_pkg::ST_GCD_INIT: begin
            if (!sts.arith || sts.den_zero) state_in = rau_pkg::ST_DONE;
            else state_in = rau_pkg::ST_GCD_DIV;
         end
         rau_pkg::ST_GCD_DIV: begin
            if (sts.y_zero) state_in = rau_pkg::ST_RED_NUM;
            else state_in = rau_pkg::ST_GCD_STEP;
         end
         rau_pkg::ST_GCD_STEP: if (sts.div_done) state_in = rau_pkg::ST_GCD_DIV;
         rau_pkg::ST_RED_NUM:  if (sts.div_done) state_in = rau_pkg::ST_RED_DEN;
         rau_pkg::ST_RED_DEN:  if (sts.div_done) state_in = rau_pkg::ST_IDLE;
         rau_pkg::ST_DONE:     state_in = rau_pkg::ST_IDLE;
         default:              state_in = rau_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      cmd = '0;
      unique case (state_ff)
         rau_pkg::ST_IDLE:     cmd.load = start;
         rau_pkg::ST_MUL1:     cmd.mul1 = 1'b1;
         rau_pkg::ST_MUL2:     cmd.mul2 = 1'b1;
         rau_pkg::ST_FORM:     cmd.form = 1'b1;
         rau_pkg::ST_GCD_INIT: cmd.gcd_init = 1'b1;
         rau_pkg::ST_GCD_DIV: begin
            cmd.div_start = !sts.y_zero;
            cmd.red_num   = sts.y_zero;
         end
         rau_pkg::ST_GCD_STEP: cmd.gcd_step = sts.div_done;
         rau_pkg::ST_RED_NUM: begin
            cmd.red_den = sts.div_done;
         end
         rau_pkg::ST_RED_DEN:  cmd.finish = sts.div_done;
         rau_pkg::ST_DONE:     cmd.finish = 1'b1;
         default:              cmd = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= rau_pkg::ST_IDLE;
         strobe_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         strobe_ff <= cmd.finish;
      end
   end

   assign busy   = (state_ff != rau_pkg::ST_IDLE);
   assign strobe = strobe_ff;
endmodule
